// ===== design/cibc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the configuration image blank check block.
package cibc_pkg;

    localparam int MAX_BYTES  = 256;
    localparam int COUNT_W    = 9;
    localparam int LEN_W      = COUNT_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_BYTES = 3'd0,
        CFG_SIG_A_INDEX = 3'd1,
        CFG_SIG_A_VALUE = 3'd2,
        CFG_SIG_B_INDEX = 3'd3,
        CFG_SIG_B_VALUE = 3'd4,
        CFG_TRIM_INDEX  = 3'd5,
        CFG_ID_INDEX    = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_EMPTY        = 2'd0,
        KIND_PROGRAMMED   = 2'd1,
        KIND_UNRECOGNIZED = 2'd2
    } image_kind_t;

    typedef struct packed {
        logic [7:0]  pattern_id;
        image_kind_t image_kind;
    } result_t;

    localparam logic [8:0] RST_TOTAL_BYTES = 9'd256;
    localparam logic [7:0] RST_SIG_A_INDEX = 8'h7f;
    localparam logic [7:0] RST_SIG_A_VALUE = 8'h5a;
    localparam logic [7:0] RST_SIG_B_INDEX = 8'hff;
    localparam logic [7:0] RST_SIG_B_VALUE = 8'ha5;
    localparam logic [7:0] RST_TRIM_INDEX  = 8'hf7;
    localparam logic [7:0] RST_ID_INDEX    = 8'hfd;

endpackage

// ===== design/config_image_blank_check.sv =====
`timescale 1ns / 1ps
// Configuration image blank check: classifies a readback image byte stream.
// Throughput: one byte per cycle while the output buffer has a free entry.
// The tlast byte's result is registered into the output buffer that drives m_tvalid.
// s_tready drops only while both output buffer entries hold results.
// Reset: rst_n clears the image state, output buffer and registers to defaults.
module config_image_blank_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tlast,      // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [1:0] image_kind, [9:2] pattern_id, [15:10] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cibc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cibc_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [8:0] total_reg;
    logic [7:0] sig_a_index_reg;
    logic [7:0] sig_a_value_reg;
    logic [7:0] sig_b_index_reg;
    logic [7:0] sig_b_value_reg;
    logic [7:0] trim_index_reg;
    logic [7:0] id_index_reg;

    logic [cibc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         sig_ok_reg, sig_ok_next;
    logic                         nonzero_reg, nonzero_next;
    logic [7:0]                   id_reg, id_next;

    cibc_pkg::result_t out_reg, skid_reg, push_res;
    logic              out_valid_reg, skid_valid_reg;

    logic       in_accept, push;
    logic       trim_hit, sig_a_hit, sig_b_hit;
    logic [7:0] masked;
    logic [8:0] trim_pos1, id_pos1;
    logic [cibc_pkg::LEN_W-1:0] length;
    logic       length_bad;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign push      = in_accept && s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= cibc_pkg::RST_TOTAL_BYTES;
            sig_a_index_reg <= cibc_pkg::RST_SIG_A_INDEX;
            sig_a_value_reg <= cibc_pkg::RST_SIG_A_VALUE;
            sig_b_index_reg <= cibc_pkg::RST_SIG_B_INDEX;
            sig_b_value_reg <= cibc_pkg::RST_SIG_B_VALUE;
            trim_index_reg  <= cibc_pkg::RST_TRIM_INDEX;
            id_index_reg    <= cibc_pkg::RST_ID_INDEX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cibc_pkg::cfg_index_t'(cfg_index))
                cibc_pkg::CFG_TOTAL_BYTES: total_reg       <= cfg_data;
                cibc_pkg::CFG_SIG_A_INDEX: sig_a_index_reg <= cfg_data[7:0];
                cibc_pkg::CFG_SIG_A_VALUE: sig_a_value_reg <= cfg_data[7:0];
                cibc_pkg::CFG_SIG_B_INDEX: sig_b_index_reg <= cfg_data[7:0];
                cibc_pkg::CFG_SIG_B_VALUE: sig_b_value_reg <= cfg_data[7:0];
                cibc_pkg::CFG_TRIM_INDEX:  trim_index_reg  <= cfg_data[7:0];
                cibc_pkg::CFG_ID_INDEX:    id_index_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        trim_pos1 = {1'b0, trim_index_reg} + 9'd1;
        id_pos1   = {1'b0, id_index_reg} + 9'd1;
        trim_hit  = (count_reg == {1'b0, trim_index_reg}) || (count_reg == trim_pos1);
        masked    = trim_hit ? 8'd0 : s_tdata;
        sig_a_hit = (count_reg == {1'b0, sig_a_index_reg});
        sig_b_hit = (count_reg == {1'b0, sig_b_index_reg});

        sig_ok_next = sig_ok_reg;
        if (sig_a_hit && (masked != sig_a_value_reg))
            sig_ok_next = 1'b0;
        if (sig_b_hit && (masked != sig_b_value_reg))
            sig_ok_next = 1'b0;

        nonzero_next = nonzero_reg || (!sig_a_hit && !sig_b_hit && (masked != 8'd0));

        id_next = id_reg;
        if (count_reg == {1'b0, id_index_reg})
            id_next[0] = s_tdata[7];
        if (count_reg == id_pos1)
            id_next[7:1] = s_tdata[6:0];

        length     = {1'b0, count_reg} + cibc_pkg::LEN_W'(1);
        length_bad = (length != {1'b0, total_reg})
                     || (length > cibc_pkg::LEN_W'(cibc_pkg::MAX_BYTES));

        if (length_bad)
        begin
            push_res.image_kind = cibc_pkg::KIND_UNRECOGNIZED;
            push_res.pattern_id = 8'd0;
        end
        else
        begin
            if (!sig_ok_next)
                push_res.image_kind = cibc_pkg::KIND_UNRECOGNIZED;
            else if (nonzero_next)
                push_res.image_kind = cibc_pkg::KIND_PROGRAMMED;
            else
                push_res.image_kind = cibc_pkg::KIND_EMPTY;
            push_res.pattern_id = id_next;
        end

        count_next = (count_reg == cibc_pkg::COUNT_MAX) ? count_reg : count_reg + 9'd1;
    end

    // Advance the image state on each byte; clear it after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sig_ok_reg  <= 1'b1;
            nonzero_reg <= 1'b0;
            id_reg      <= 8'd0;
        end
        else if (in_accept)
        begin
            if (s_tlast)
            begin
                count_reg   <= '0;
                sig_ok_reg  <= 1'b1;
                nonzero_reg <= 1'b0;
                id_reg      <= 8'd0;
            end
            else
            begin
                count_reg   <= count_next;
                sig_ok_reg  <= sig_ok_next;
                nonzero_reg <= nonzero_next;
                id_reg      <= id_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !m_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !m_tready)
                skid_reg <= push_res;
            else
                out_reg <= push_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule

// ===== design/cibc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the configuration image blank check block, with its bind.
module cibc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output is empty");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a last item");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[15:10] == 6'd0))
        else $error("bad result encoding");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind config_image_blank_check cibc_checker u_cibc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
